// ===== src/imuca_pkg.sv =====
// ----------------------------------------------------------------------------
// imuca_pkg
// shared types, constants and tables for the complementary attitude filter
// ----------------------------------------------------------------------------
`default_nettype none

package imuca_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int OUT_SHIFT       = 16 - ANGLE_FRAC_BITS;
    localparam int SQRT_STEPS      = 30;
    localparam int ARITH_STEPS     = 8;
    localparam int STEP_W          = 5;
    localparam int CW              = 34;
    localparam int CFG_IDX_W       = 2;

    localparam logic signed [33:0] Q16_180 = 34'sd11796480;
    localparam logic signed [33:0] Q16_360 = 34'sd23592960;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_ALPHA = 2'd0,
        REG_GYRO_STEP   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } raw_sample_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } attitude_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_SQRT,
        ST_PINIT,
        ST_PITCH,
        ST_PSAVE,
        ST_ARITH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              mag;
        logic              sqrt_en;
        logic              cordic_en;
        logic              init_pitch;
        logic              save_roll;
        logic              save_pitch;
        logic              arith_en;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // atan(2^-i) in q16 degrees
    function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [21:0] v;
        begin
            unique case (i)
                5'd0:  v = 22'd2949120;
                5'd1:  v = 22'd1740967;
                5'd2:  v = 22'd919879;
                5'd3:  v = 22'd466945;
                5'd4:  v = 22'd234379;
                5'd5:  v = 22'd117304;
                5'd6:  v = 22'd58666;
                5'd7:  v = 22'd29335;
                5'd8:  v = 22'd14668;
                5'd9:  v = 22'd7334;
                5'd10: v = 22'd3667;
                5'd11: v = 22'd1833;
                5'd12: v = 22'd917;
                5'd13: v = 22'd458;
                5'd14: v = 22'd229;
                5'd15: v = 22'd115;
                5'd16: v = 22'd57;
                5'd17: v = 22'd29;
                5'd18: v = 22'd14;
                5'd19: v = 22'd7;
                5'd20: v = 22'd4;
                5'd21: v = 22'd2;
                5'd22: v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/imu_complementary_attitude.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// complementary filter: roll, pitch, yaw from raw six-axis samples
// ----------------------------------------------------------------------------
//  channel   prefix  payload        handshake
//  sample    s_      raw_sample_t   valid / ready
//  attitude  m_      attitude_t     valid / ready
//  config    cfg_    16-bit data    write enable, no wait
//
//  steps per sample: load, magnitude, 30 sqrt steps (roll cordic runs alongside),
//  pitch cordic, 8 multiply/blend steps, output load when the output is free.
//  the single shared cordic unit and the sequential sqrt set this sequence.
//  a new sample is taken while the previous result waits in the output register.
//  reset restores register defaults and clears the filter state.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_attitude import imuca_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire raw_sample_t          s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output attitude_t                 m_data
);

    cmd_t cmd;

    imuca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    imuca_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== src/imuca_dp.sv =====
// ----------------------------------------------------------------------------
// imuca_dp
// datapath: square root, shared cordic, gyro integration and blend
// ----------------------------------------------------------------------------
`default_nettype none

module imuca_dp import imuca_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire raw_sample_t          s_data,
    input  wire cmd_t                 cmd,
    output attitude_t                 m_data
);

    logic [15:0]        alpha_reg, gstep_reg;
    logic               seeded_reg;
    logic signed [31:0] roll_reg, pitch_reg, yaw_reg;
    raw_sample_t        smp_reg;
    logic [59:0]        sq_v_reg, sq_r_reg, sq_b_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic               czero_reg;
    logic signed [31:0] acc_roll_reg, acc_pitch_reg;
    logic signed [51:0] prod_reg, sum_reg;
    logic signed [25:0] ix_reg, iy_reg, iz_reg;
    attitude_t          out_reg;

    logic signed [17:0] mul_a;
    logic signed [CW-1:0] mul_b;
    logic signed [51:0] prod;
    logic [59:0]        sq_t;
    logic signed [CW-1:0] ix0, iy0, dx, dy;
    logic signed [31:0] atn;
    logic signed [51:0] rnd_sum;
    logic signed [52:0] blend_sum;
    logic signed [36:0] blend_sh;
    logic signed [31:0] blend_sat;
    logic signed [33:0] yaw_sum, yaw_wrap;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -37'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [31:0] q);
        logic signed [32:0] t;
        logic signed [32:0] s;
        begin
            t = 33'(q) + (33'sd1 <<< (OUT_SHIFT - 1));
            s = t >>> OUT_SHIFT;
            if (s > 33'sd32767) begin
                return 16'sh7fff;
            end else if (s < -33'sd32768) begin
                return 16'sh8000;
            end
            return s[15:0];
        end
    endfunction

    // cordic pre-rotation inputs
    always_comb begin
        if (cmd.init_pitch) begin
            iy0 = -(CW'(smp_reg.accel_x) <<< 14);
            ix0 = CW'({1'b0, sq_r_reg[29:0]});
        end else begin
            iy0 = CW'(s_data.accel_y) <<< 14;
            ix0 = CW'(s_data.accel_z) <<< 14;
        end
    end

    assign dx   = cy_reg >>> cmd.step;
    assign dy   = cx_reg >>> cmd.step;
    assign atn  = 32'(atan_q16(cmd.step));
    assign sq_t = sq_r_reg + sq_b_reg;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            5'd0: begin
                mul_a = 18'({2'b00, gstep_reg});
                mul_b = CW'(smp_reg.gyro_x);
            end
            5'd1: begin
                mul_a = 18'({2'b00, gstep_reg});
                mul_b = CW'(smp_reg.gyro_y);
            end
            5'd2: begin
                mul_a = 18'({2'b00, gstep_reg});
                mul_b = CW'(smp_reg.gyro_z);
            end
            5'd3: begin
                mul_a = 18'({2'b00, alpha_reg});
                mul_b = CW'(roll_reg) + CW'(ix_reg);
            end
            5'd4: begin
                mul_a = 18'sd65536 - 18'({2'b00, alpha_reg});
                mul_b = CW'(acc_roll_reg);
            end
            5'd5: begin
                mul_a = 18'({2'b00, alpha_reg});
                mul_b = CW'(pitch_reg) + CW'(iy_reg);
            end
            5'd6: begin
                mul_a = 18'sd65536 - 18'({2'b00, alpha_reg});
                mul_b = CW'(acc_pitch_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = 52'(mul_a * mul_b);
    assign rnd_sum   = prod_reg + 52'sd128;
    assign blend_sum = 53'(sum_reg) + 53'(prod_reg) + 53'sd32768;
    assign blend_sh  = 37'(blend_sum >>> 16);
    assign blend_sat = sat32(blend_sh);
    assign yaw_sum   = 34'(yaw_reg) + 34'(iz_reg);

    always_comb begin
        if (yaw_sum > Q16_180) begin
            yaw_wrap = yaw_sum - Q16_360;
        end else if (yaw_sum < -Q16_180) begin
            yaw_wrap = yaw_sum + Q16_360;
        end else begin
            yaw_wrap = yaw_sum;
        end
    end

    // configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= 16'd64225;
            gstep_reg  <= 16'd2561;
            seeded_reg <= 1'b0;
            roll_reg   <= '0;
            pitch_reg  <= '0;
            yaw_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BLEND_ALPHA: alpha_reg <= cfg_data;
                    REG_GYRO_STEP:   gstep_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.arith_en && cmd.step == 5'd5 && seeded_reg) begin
                roll_reg <= blend_sat;
            end
            if (cmd.arith_en && cmd.step == 5'd7) begin
                if (seeded_reg) begin
                    pitch_reg <= blend_sat;
                    yaw_reg   <= yaw_wrap[31:0];
                end else begin
                    roll_reg   <= acc_roll_reg;
                    pitch_reg  <= acc_pitch_reg;
                    yaw_reg    <= '0;
                    seeded_reg <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            smp_reg  <= s_data;
            sq_v_reg <= 60'(32'(s_data.accel_y * s_data.accel_y));
        end
        if (cmd.mag) begin
            sq_v_reg <= (sq_v_reg + 60'(32'(smp_reg.accel_z * smp_reg.accel_z))) << 28;
            sq_r_reg <= '0;
            sq_b_reg <= 60'd1 << 58;
        end
        if (cmd.sqrt_en) begin
            if (sq_v_reg >= sq_t) begin
                sq_v_reg <= sq_v_reg - sq_t;
                sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_b_reg <= sq_b_reg >> 2;
        end
        if (cmd.load || cmd.init_pitch) begin
            czero_reg <= (ix0 == '0) && (iy0 == '0);
            if (ix0 < 0) begin
                cz_reg <= (iy0 >= 0) ? Q16_180[31:0] : -Q16_180[31:0];
                cx_reg <= -ix0;
                cy_reg <= -iy0;
            end else begin
                cz_reg <= '0;
                cx_reg <= ix0;
                cy_reg <= iy0;
            end
        end else if (cmd.cordic_en) begin
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atn;
            end else begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atn;
            end
        end
        if (cmd.save_roll) begin
            acc_roll_reg <= czero_reg ? '0 : cz_reg;
        end
        if (cmd.save_pitch) begin
            acc_pitch_reg <= czero_reg ? '0 : cz_reg;
        end
        if (cmd.arith_en) begin
            prod_reg <= prod;
            case (cmd.step)
                5'd1: ix_reg <= rnd_sum[33:8];
                5'd2: iy_reg <= rnd_sum[33:8];
                5'd3: iz_reg <= rnd_sum[33:8];
                5'd4: sum_reg <= prod_reg;
                5'd6: sum_reg <= prod_reg;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            out_reg.roll_angle  <= to_out(roll_reg);
            out_reg.pitch_angle <= to_out(pitch_reg);
            out_reg.yaw_angle   <= to_out(yaw_reg);
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ===== src/imuca_ctrl.sv =====
// ----------------------------------------------------------------------------
// imuca_ctrl
// sequencer for one sample: magnitude, sqrt with roll cordic, pitch, blend
// ----------------------------------------------------------------------------
`default_nettype none

module imuca_ctrl import imuca_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_en   = 1'b1;
                cmd.cordic_en = cnt_reg < STEP_W'(CORDIC_STEPS);
                cmd.save_roll = cnt_reg == STEP_W'(CORDIC_STEPS);
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_PINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PINIT: begin
                cmd.init_pitch = 1'b1;
                cnt_next       = '0;
                state_next     = ST_PITCH;
            end
            ST_PITCH: begin
                cmd.cordic_en = 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_PSAVE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PSAVE: begin
                cmd.save_pitch = 1'b1;
                cnt_next       = '0;
                state_next     = ST_ARITH;
            end
            ST_ARITH: begin
                cmd.arith_en = 1'b1;
                if (cnt_reg == STEP_W'(ARITH_STEPS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MAG))
        else $error("accepted sample did not start magnitude step");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load did not raise valid");
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mag, cmd.sqrt_en, cmd.init_pitch, cmd.save_pitch,
                  cmd.arith_en, cmd.out_load}))
        else $error("conflicting datapath commands");
    a_arith_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ARITH) |-> (cnt_reg < STEP_W'(ARITH_STEPS)))
        else $error("arithmetic step out of range");
`endif

endmodule

`default_nettype wire
